>>> design/ptcs_pkg.sv
// Shared types, constants and the curve generator for the pedal torque command shaper.
package ptcs_pkg;

    // Port and field widths
    localparam int SAMPLE_W      = 12;
    localparam int SAMPLE_FIELDS = 4;
    localparam int GEAR_W        = 2;
    localparam int TORQUE_W      = 16;
    localparam int MAXT_W        = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;

    // Throttle figure 0..100 and the curve index space
    localparam int THR_W       = 7;
    localparam int CURVE_DEPTH = 1 << THR_W;

    // Divider operands: |avg - min| * 100 fits in 19 bits, span in 12 bits
    localparam int NUM_W = 19;
    localparam int DEN_W = SAMPLE_W;

    // Parameter defaults
    localparam int SAMPLE_COUNT_DEF    = 4;
    localparam int CURVE_FRAC_BITS_DEF = 16;

    // Shaping constants
    localparam int THR_FULL  = 100;
    localparam int THR_LOW   = 5;
    localparam int STEP_RISE = 8;
    localparam int STEP_FALL = 25;
    localparam int DB_ENTER  = 18;
    localparam int DB_LEAVE  = 25;

    // 100^9, for the exact curve entries
    localparam logic [63:0] POW100_9 = 64'd1000000000000000000;

    localparam logic [SAMPLE_W-1:0] PEDAL_MAX_RST = 12'hFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEDAL_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REVERSE = 2'd3;

    // Gear codes; anything other than neutral or drive acts as reverse
    localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE   = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_SCALE,
        S_THR_START,
        S_THR_WAIT,
        S_CURVE,
        S_SHAPE
    } t_state;

    typedef struct packed {
        logic     load_sum;
        logic     div_start;
        logic     load_avg;
        logic     load_scale;
        logic     load_thr;
        logic     load_prod;
        logic     commit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

    // floor(2^F * (t/100)^1.8): largest y with y^5 * 100^9 <= t^9 * 2^(5F).
    // Evaluated at elaboration only.
    function automatic logic [31:0] curve_entry(input int t, input int frac_bits);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] sq;
        logic [31:0]  y;
        logic [31:0]  cand;
        y = '0;
        if (t > THR_FULL) begin
            return '0;
        end
        rhs = 256'd1;
        for (int k = 0; k < 9; k++) begin
            rhs = rhs * 256'(t);
        end
        rhs = rhs << (5 * frac_bits);
        for (int b = frac_bits; b >= 0; b--) begin
            cand = y | (32'd1 << b);
            sq   = 256'(cand) * 256'(cand);
            lhs  = sq * sq * 256'(cand) * 256'(POW100_9);
            if (lhs <= rhs) begin
                y = cand;
            end
        end
        return y;
    endfunction

endpackage

>>> design/ptcs_div.sv
// Restoring divider, one quotient bit per cycle.
module ptcs_div #(
    parameter int DIVIDEND_W = ptcs_pkg::NUM_W,
    parameter int DIVISOR_W  = ptcs_pkg::DEN_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial;
    logic                  take;
    logic [DIVISOR_W-1:0]  n_rem;

    // Quotient bits shift in from the bottom as dividend bits shift out the top
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        take  = trial >= {1'b0, r_dvs};
        n_rem = take ? DIVISOR_W'(trial - {1'b0, r_dvs}) : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], take};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> design/ptcs_ctrl.sv
// Sequencer for one item: average, scale, divide, curve, shape, commit.
module ptcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ptcs_pkg::t_status i_status,
    output ptcs_pkg::t_cmd    o_cmd
);

    ptcs_pkg::t_state r_state;
    ptcs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ptcs_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_sum = 1'b1;
                    n_state        = ptcs_pkg::S_AVG;
                end
            end
            ptcs_pkg::S_AVG: begin
                o_cmd.load_avg = 1'b1;
                n_state        = ptcs_pkg::S_SCALE;
            end
            ptcs_pkg::S_SCALE: begin
                o_cmd.load_scale = 1'b1;
                n_state          = ptcs_pkg::S_THR_START;
            end
            ptcs_pkg::S_THR_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ptcs_pkg::S_THR_WAIT;
            end
            ptcs_pkg::S_THR_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.load_thr = 1'b1;
                    n_state        = ptcs_pkg::S_CURVE;
                end
            end
            ptcs_pkg::S_CURVE: begin
                o_cmd.load_prod = 1'b1;
                n_state         = ptcs_pkg::S_SHAPE;
            end
            ptcs_pkg::S_SHAPE: begin
                // hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ptcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptcs_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ptcs_dp.sv
// Datapath: config registers, sample sum, divider, curve scaling, rate limit and deadband.
module ptcs_dp #(
    parameter int SAMPLE_COUNT    = ptcs_pkg::SAMPLE_COUNT_DEF,
    parameter int CURVE_FRAC_BITS = ptcs_pkg::CURVE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptcs_pkg::t_cmd                      i_cmd,
    output ptcs_pkg::t_status                   o_status,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]       i_pedal_sample_0,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]       i_pedal_sample_1,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]       i_pedal_sample_2,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]       i_pedal_sample_3,
    input  logic [ptcs_pkg::GEAR_W-1:0]         i_gear,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ptcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ptcs_pkg::TORQUE_W-1:0] o_torque_command,
    output logic                                o_drive_enable
);

    localparam int SAMPLE_W = ptcs_pkg::SAMPLE_W;
    localparam int NUM_W    = ptcs_pkg::NUM_W;
    localparam int NUM_S_W  = NUM_W + 1;
    localparam int DEN_W    = ptcs_pkg::DEN_W;
    localparam int THR_W    = ptcs_pkg::THR_W;
    localparam int MAXT_W   = ptcs_pkg::MAXT_W;
    localparam int TORQUE_W = ptcs_pkg::TORQUE_W;
    localparam int SH_W     = TORQUE_W + 2;
    localparam int SUM_W    = $clog2(SAMPLE_COUNT * ((1 << SAMPLE_W) - 1) + 1);
    localparam int SUM_Q    = SAMPLE_COUNT / ptcs_pkg::SAMPLE_FIELDS;
    localparam int SUM_R    = SAMPLE_COUNT % ptcs_pkg::SAMPLE_FIELDS;
    localparam int CURVE_W  = CURVE_FRAC_BITS + 1;
    localparam int PROD_W   = CURVE_W + MAXT_W;

    // Average by a rounded-up reciprocal of the sample count; exact over the sum's range
    localparam int AVG_SH     = SUM_W + $clog2(SAMPLE_COUNT);
    localparam int AVG_MUL    = ((1 << AVG_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int AVG_MUL_W  = SUM_W + 2;
    localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;

    // Configuration
    logic [SAMPLE_W-1:0] r_pedal_min;
    logic [SAMPLE_W-1:0] r_pedal_max;
    logic [MAXT_W-1:0]   r_max_fwd;
    logic [MAXT_W-1:0]   r_max_rev;

    // Per-item working registers
    logic [SUM_W-1:0]              r_sum;
    logic [ptcs_pkg::GEAR_W-1:0]   r_gear;
    logic [SAMPLE_W-1:0]           r_avg;
    logic [NUM_W-1:0]              r_num_abs;
    logic [DEN_W-1:0]              r_den_abs;
    logic                          r_thr_ok;
    logic [THR_W-1:0]              r_thr;
    logic [PROD_W-1:0]             r_prod;

    // Persistent shaping state
    logic signed [TORQUE_W-1:0]    r_prev;
    logic                          r_in_db;
    logic                          r_en;

    // Output register
    logic                          r_out_valid;
    logic signed [TORQUE_W-1:0]    r_torque;
    logic                          r_out_en;

    // Curve constants
    logic [CURVE_W-1:0] curve_rom [ptcs_pkg::CURVE_DEPTH];

    for (genvar g = 0; g < ptcs_pkg::CURVE_DEPTH; g++) begin : g_curve
        localparam logic [31:0] ENTRY = ptcs_pkg::curve_entry(g, CURVE_FRAC_BITS);
        assign curve_rom[g] = ENTRY[CURVE_W-1:0];
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pedal_min <= '0;
            r_pedal_max <= ptcs_pkg::PEDAL_MAX_RST;
            r_max_fwd   <= '0;
            r_max_rev   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptcs_pkg::REG_PEDAL_MIN:   r_pedal_min <= i_cfg_data[SAMPLE_W-1:0];
                ptcs_pkg::REG_PEDAL_MAX:   r_pedal_max <= i_cfg_data[SAMPLE_W-1:0];
                ptcs_pkg::REG_MAX_FORWARD: r_max_fwd   <= i_cfg_data[MAXT_W-1:0];
                ptcs_pkg::REG_MAX_REVERSE: r_max_rev   <= i_cfg_data[MAXT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample sum: whole groups of the four fields, then a partial group
    logic [NUM_W-1:0] sum_all;
    logic [NUM_W-1:0] sum_part;
    logic [SUM_W-1:0] n_sum;

    always_comb begin
        sum_all = NUM_W'(i_pedal_sample_0) + NUM_W'(i_pedal_sample_1)
                + NUM_W'(i_pedal_sample_2) + NUM_W'(i_pedal_sample_3);
        sum_part = '0;
        if (SUM_R > 0) begin
            sum_part = sum_part + NUM_W'(i_pedal_sample_0);
        end
        if (SUM_R > 1) begin
            sum_part = sum_part + NUM_W'(i_pedal_sample_1);
        end
        if (SUM_R > 2) begin
            sum_part = sum_part + NUM_W'(i_pedal_sample_2);
        end
        n_sum = SUM_W'(NUM_W'(SUM_Q) * sum_all + sum_part);
    end

    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SAMPLE_W-1:0]   n_avg;

    always_comb begin
        avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_MUL);
        n_avg    = avg_prod[AVG_SH +: SAMPLE_W];
    end

    // Divider for the pedal scaling
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    ptcs_div #(
        .DIVIDEND_W (NUM_W),
        .DIVISOR_W  (DEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num_abs),
        .i_divisor  (r_den_abs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Scaling: signed (avg - min) * 100 over (max - min), split into sign and magnitudes
    logic signed [SAMPLE_W:0] avg_ofs;
    logic signed [SAMPLE_W:0] den_s;
    logic signed [NUM_S_W-1:0] num_s;
    logic [NUM_W-1:0]          num_abs;
    logic [DEN_W-1:0]          den_abs;
    logic                      thr_ok;
    logic [THR_W-1:0]          n_thr;

    always_comb begin
        avg_ofs = $signed({1'b0, r_avg}) - $signed({1'b0, r_pedal_min});
        den_s   = $signed({1'b0, r_pedal_max}) - $signed({1'b0, r_pedal_min});
        num_s   = NUM_S_W'(avg_ofs) * NUM_S_W'(ptcs_pkg::THR_FULL);
        num_abs = num_s[NUM_W] ? NUM_W'(-num_s) : num_s[NUM_W-1:0];
        den_abs = den_s[SAMPLE_W] ? DEN_W'(-den_s) : den_s[DEN_W-1:0];
        // quotient is positive only for a nonzero span and same-sign operands
        thr_ok  = (den_s != '0) && (num_s != '0) && (num_s[NUM_W] == den_s[SAMPLE_W]);
        if (!r_thr_ok) begin
            n_thr = '0;
        end else if (div_quo > NUM_W'(ptcs_pkg::THR_FULL)) begin
            n_thr = THR_W'(ptcs_pkg::THR_FULL);
        end else begin
            n_thr = div_quo[THR_W-1:0];
        end
    end

    // Curve times the gear's maximum
    logic [MAXT_W-1:0] maxt;
    logic [PROD_W-1:0] n_prod;

    always_comb begin
        maxt   = (r_gear == ptcs_pkg::GEAR_DRIVE) ? r_max_fwd : r_max_rev;
        n_prod = PROD_W'(curve_rom[r_thr]) * PROD_W'(maxt);
    end

    // Rate limit, low-throttle cut, deadband
    logic [MAXT_W-1:0]          mag;
    logic [MAXT_W-1:0]          prev_abs;
    logic [MAXT_W-1:0]          lim_abs;
    logic signed [SH_W-1:0]     cmd_s;
    logic signed [SH_W-1:0]     prev_s;
    logic signed [SH_W-1:0]     diff;
    logic signed [SH_W-1:0]     step;
    logic signed [SH_W-1:0]     lim;
    logic signed [TORQUE_W-1:0] lim_t;
    logic signed [TORQUE_W-1:0] out_cmd;
    logic signed [TORQUE_W-1:0] n_prev;
    logic                       rising;
    logic                       n_in_db;
    logic                       n_en;
    logic                       out_en;

    always_comb begin
        mag    = r_prod[CURVE_FRAC_BITS +: MAXT_W];
        prev_s = SH_W'(r_prev);
        cmd_s  = $signed(SH_W'(mag));
        if (r_gear == ptcs_pkg::GEAR_DRIVE) begin
            cmd_s = -cmd_s;
        end
        prev_abs = r_prev[TORQUE_W-1] ? MAXT_W'(-r_prev) : MAXT_W'(r_prev);
        rising   = mag > prev_abs;
        step     = rising ? SH_W'(ptcs_pkg::STEP_RISE) : SH_W'(ptcs_pkg::STEP_FALL);
        diff     = cmd_s - prev_s;
        if (diff > step) begin
            lim = prev_s + step;
        end else if (diff < -step) begin
            lim = prev_s - step;
        end else begin
            lim = cmd_s;
        end
        lim_t   = TORQUE_W'(lim);
        lim_abs = lim_t[TORQUE_W-1] ? MAXT_W'(-lim_t) : MAXT_W'(lim_t);
        if ((r_thr < THR_W'(ptcs_pkg::THR_LOW)) && (lim_abs > prev_abs)) begin
            lim_t   = '0;
            lim_abs = '0;
        end
        n_prev  = lim_t;
        n_in_db = r_in_db;
        out_cmd = lim_t;
        if (r_in_db) begin
            if (lim_abs > MAXT_W'(ptcs_pkg::DB_LEAVE)) begin
                n_in_db = 1'b0;
                n_en    = 1'b1;
            end else begin
                out_cmd = '0;
                n_en    = 1'b0;
            end
        end else begin
            if (lim_abs < MAXT_W'(ptcs_pkg::DB_ENTER)) begin
                n_in_db = 1'b1;
                out_cmd = '0;
                n_en    = 1'b0;
            end else begin
                n_en = 1'b1;
            end
        end
        out_en = n_en;
        // released pedal and neutral bypass the shaping and leave the deadband alone
        if (r_thr == '0) begin
            n_prev  = '0;
            n_in_db = r_in_db;
            out_cmd = '0;
            n_en    = 1'b0;
            out_en  = 1'b0;
        end else if (r_gear == ptcs_pkg::GEAR_NEUTRAL) begin
            n_prev  = '0;
            n_in_db = r_in_db;
            out_cmd = '0;
            n_en    = r_en;
            out_en  = r_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sum) begin
            r_sum  <= n_sum;
            r_gear <= i_gear;
        end
        if (i_cmd.load_avg) begin
            r_avg <= n_avg;
        end
        if (i_cmd.load_scale) begin
            r_num_abs <= num_abs;
            r_den_abs <= den_abs;
            r_thr_ok  <= thr_ok;
        end
        if (i_cmd.load_thr) begin
            r_thr <= n_thr;
        end
        if (i_cmd.load_prod) begin
            r_prod <= n_prod;
        end
        if (i_cmd.commit) begin
            r_torque <= out_cmd;
            r_out_en <= out_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_in_db     <= 1'b0;
            r_en        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_prev      <= n_prev;
                r_in_db     <= n_in_db;
                r_en        <= n_en;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_torque_command = r_torque;
    assign o_drive_enable   = r_out_en;

endmodule

>>> design/pedal_torque_command_shaper.sv
// Top level of the pedal torque command shaper.
// Each input item (pedal ADC samples and gear) yields one result item: a signed
// torque command and the drive enable flag. The samples are averaged, scaled
// against the pedal_min/pedal_max calibration into a 0..100 throttle figure,
// shaped by a (throttle/100)^1.8 curve times the forward or reverse maximum,
// then rate limited and passed through a deadband with hysteresis. One item is
// worked on at a time, and the input stays stalled from acceptance until its commit
// into the output register. The throttle scaling uses the restoring divider (one
// quotient bit per cycle, 19-bit dividend); the average is a reciprocal multiply.
// A finished item waits while the output register still holds an unaccepted
// result, and the input stays stalled until then. The output register holds a
// finished item while the next one is taken in and worked on. Configuration
// writes are always ready and must only be made while idle.
module pedal_torque_command_shaper #(
    parameter int SAMPLE_COUNT    = ptcs_pkg::SAMPLE_COUNT_DEF,
    parameter int CURVE_FRAC_BITS = ptcs_pkg::CURVE_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_0,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_1,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_2,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_3,
    input  logic [ptcs_pkg::GEAR_W-1:0]          i_gear,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [ptcs_pkg::TORQUE_W-1:0] o_torque_command,
    output logic                                 o_drive_enable,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ptcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ptcs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    ptcs_pkg::t_cmd    cmd;
    ptcs_pkg::t_status status;

    ptcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptcs_dp #(
        .SAMPLE_COUNT    (SAMPLE_COUNT),
        .CURVE_FRAC_BITS (CURVE_FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_pedal_sample_0 (i_pedal_sample_0),
        .i_pedal_sample_1 (i_pedal_sample_1),
        .i_pedal_sample_2 (i_pedal_sample_2),
        .i_pedal_sample_3 (i_pedal_sample_3),
        .i_gear           (i_gear),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_torque_command (o_torque_command),
        .o_drive_enable   (o_drive_enable)
    );

endmodule

>>> sim/ptcs_torque_checker.sv
`timescale 1ns / 1ps
// Torque command checker: predicts each result of the pedal torque command shaper and compares it.
module ptcs_torque_checker #(
    parameter int SAMPLE_COUNT    = ptcs_pkg::SAMPLE_COUNT_DEF,
    parameter int CURVE_FRAC_BITS = ptcs_pkg::CURVE_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_0,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_1,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_2,
    input  logic [ptcs_pkg::SAMPLE_W-1:0]        i_pedal_sample_3,
    input  logic [ptcs_pkg::GEAR_W-1:0]          i_gear,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [ptcs_pkg::TORQUE_W-1:0] i_torque_command,
    input  logic                                 i_drive_enable,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [ptcs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ptcs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_pending,
    output int                                   o_fail_count,
    output int                                   o_results_checked
);

    typedef struct packed {
        logic signed [ptcs_pkg::TORQUE_W-1:0] torque;
        logic                                 enable;
    } t_torque_result;

    t_torque_result torque_due [$];

    logic [31:0]                   throttle_curve [0:ptcs_pkg::THR_FULL];
    logic [ptcs_pkg::SAMPLE_W-1:0] pedal_min;
    logic [ptcs_pkg::SAMPLE_W-1:0] pedal_max;
    logic [ptcs_pkg::MAXT_W-1:0]   fwd_limit;
    logic [ptcs_pkg::MAXT_W-1:0]   rev_limit;
    int                            last_torque;
    bit                            in_deadband;
    bit                            enable_flag;
    int                            fails;
    int                            checked;

    // Largest y with y^5 * 100^9 <= t^9 * 2^(5F), found by bisection.
    function automatic logic [31:0] curve_point(input int t);
        logic [191:0] bound;
        logic [191:0] probe;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        bound = 192'd1;
        for (int k = 0; k < 9; k++) bound = bound * 192'(t);
        bound = bound << (5 * CURVE_FRAC_BITS);
        lo = '0;
        hi = 32'd1 << CURVE_FRAC_BITS;
        while (lo < hi) begin
            mid   = lo + (hi - lo + 32'd1) / 32'd2;
            probe = 192'(mid);
            for (int k = 0; k < 4; k++) probe = probe * 192'(mid);
            probe = probe * 192'd1000000000 * 192'd1000000000;
            if (probe <= bound) begin
                lo = mid;
            end else begin
                hi = mid - 32'd1;
            end
        end
        return lo;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    initial begin
        for (int t = 0; t <= ptcs_pkg::THR_FULL; t++) throttle_curve[t] = curve_point(t);
    end

    task automatic predict_torque(input logic [3:0][ptcs_pkg::SAMPLE_W-1:0] samples,
                                  input logic [ptcs_pkg::GEAR_W-1:0] gear,
                                  output t_torque_result res);
        int unsigned sum;
        int          avg;
        int          span;
        int          thr;
        int          limit;
        int          mag;
        int          cmd;
        int          step;
        int          diff;
        longint      num;
        sum = 0;
        for (int i = 0; i < SAMPLE_COUNT; i++) sum += samples[i % ptcs_pkg::SAMPLE_FIELDS];
        avg  = int'(sum / SAMPLE_COUNT);
        span = int'(pedal_max) - int'(pedal_min);
        if (span == 0) begin
            thr = 0;
        end else begin
            num = longint'(avg - int'(pedal_min)) * ptcs_pkg::THR_FULL;
            thr = int'(num / longint'(span));
        end
        if (thr < 0) thr = 0;
        if (thr > ptcs_pkg::THR_FULL) thr = ptcs_pkg::THR_FULL;

        res.torque = '0;
        res.enable = 1'b0;
        if (thr == 0) begin
            last_torque = 0;
            enable_flag = 1'b0;
        end else if (gear == ptcs_pkg::GEAR_NEUTRAL) begin
            // enable flag is held, not cleared
            last_torque = 0;
            res.enable  = enable_flag;
        end else begin
            limit = (gear == ptcs_pkg::GEAR_DRIVE) ? int'(fwd_limit) : int'(rev_limit);
            mag   = int'((longint'(throttle_curve[thr]) * limit) >> CURVE_FRAC_BITS);
            cmd   = (gear == ptcs_pkg::GEAR_DRIVE) ? -mag : mag;
            step  = (magnitude(cmd) > magnitude(last_torque)) ? ptcs_pkg::STEP_RISE
                                                               : ptcs_pkg::STEP_FALL;
            diff  = cmd - last_torque;
            if (diff > step) begin
                cmd = last_torque + step;
            end else if (diff < -step) begin
                cmd = last_torque - step;
            end
            if (thr < ptcs_pkg::THR_LOW && magnitude(cmd) > magnitude(last_torque)) cmd = 0;
            // the rate limiter tracks the command before deadband gating
            last_torque = cmd;
            if (in_deadband) begin
                if (magnitude(cmd) > ptcs_pkg::DB_LEAVE) begin
                    in_deadband = 1'b0;
                    enable_flag = 1'b1;
                end else begin
                    cmd         = 0;
                    enable_flag = 1'b0;
                end
            end else if (magnitude(cmd) < ptcs_pkg::DB_ENTER) begin
                in_deadband = 1'b1;
                cmd         = 0;
                enable_flag = 1'b0;
            end else begin
                enable_flag = 1'b1;
            end
            res.torque = cmd[ptcs_pkg::TORQUE_W-1:0];
            res.enable = enable_flag;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_torque_result due;
        t_torque_result seen;
        if (!i_rst_n) begin
            pedal_min   = '0;
            pedal_max   = ptcs_pkg::PEDAL_MAX_RST;
            fwd_limit   = '0;
            rev_limit   = '0;
            last_torque = 0;
            in_deadband = 1'b0;
            enable_flag = 1'b0;
            fails       = 0;
            checked     = 0;
            torque_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ptcs_pkg::REG_PEDAL_MIN:   pedal_min = i_cfg_data[ptcs_pkg::SAMPLE_W-1:0];
                    ptcs_pkg::REG_PEDAL_MAX:   pedal_max = i_cfg_data[ptcs_pkg::SAMPLE_W-1:0];
                    ptcs_pkg::REG_MAX_FORWARD: fwd_limit = i_cfg_data[ptcs_pkg::MAXT_W-1:0];
                    ptcs_pkg::REG_MAX_REVERSE: rev_limit = i_cfg_data[ptcs_pkg::MAXT_W-1:0];
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen.torque = i_torque_command;
                seen.enable = i_drive_enable;
                if (torque_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected item, torque_command %0d drive_enable %0b",
                             $time, $signed(seen.torque), seen.enable);
                end else begin
                    due = torque_due.pop_front();
                    checked++;
                    if (seen.torque !== due.torque) begin
                        fails++;
                        $display("%0t: torque_command expected %0d, got %0d",
                                 $time, $signed(due.torque), $signed(seen.torque));
                    end
                    if (seen.enable !== due.enable) begin
                        fails++;
                        $display("%0t: drive_enable expected %0b, got %0b",
                                 $time, due.enable, seen.enable);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_torque({i_pedal_sample_3, i_pedal_sample_2,
                                i_pedal_sample_1, i_pedal_sample_0}, i_gear, due);
                torque_due.push_back(due);
            end
        end
        o_pending         <= torque_due.size();
        o_fail_count      <= fails;
        o_results_checked <= checked;
    end

endmodule

>>> sim/tb_pedal_torque_command_shaper.sv
`timescale 1ns / 1ps
// Testbench top for the pedal torque command shaper: stimulus, idling, watchdog and verdict.
module tb_pedal_torque_command_shaper;

    // unused gear code behaves as reverse
    localparam logic [ptcs_pkg::GEAR_W-1:0] GEAR_REVERSE = 2'd2;
    localparam logic [ptcs_pkg::GEAR_W-1:0] GEAR_SPARE   = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 60;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [ptcs_pkg::SAMPLE_W-1:0]        sample_0;
    logic [ptcs_pkg::SAMPLE_W-1:0]        sample_1;
    logic [ptcs_pkg::SAMPLE_W-1:0]        sample_2;
    logic [ptcs_pkg::SAMPLE_W-1:0]        sample_3;
    logic [ptcs_pkg::GEAR_W-1:0]          gear;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [ptcs_pkg::TORQUE_W-1:0] torque_command;
    logic                                 drive_enable;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [ptcs_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [ptcs_pkg::CFG_DATA_W-1:0]      cfg_data;

    int pending;
    int fail_count;
    int results_checked;
    int cfg_min;
    int cfg_max;
    int items_sent;
    int settings_loaded;
    int idle_cycles = 0;
    bit idling_on;
    bit calm_tail;

    pedal_torque_command_shaper dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_pedal_sample_0 (sample_0),
        .i_pedal_sample_1 (sample_1),
        .i_pedal_sample_2 (sample_2),
        .i_pedal_sample_3 (sample_3),
        .i_gear           (gear),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_torque_command (torque_command),
        .o_drive_enable   (drive_enable),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    ptcs_torque_checker torque_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_pedal_sample_0  (sample_0),
        .i_pedal_sample_1  (sample_1),
        .i_pedal_sample_2  (sample_2),
        .i_pedal_sample_3  (sample_3),
        .i_gear            (gear),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_torque_command  (torque_command),
        .i_drive_enable    (drive_enable),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_pending         (pending),
        .o_fail_count      (fail_count),
        .o_results_checked (results_checked)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver back-pressure in random bursts
    initial begin : out_stall_gen
        int burst;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 99) < 12) begin
                burst     = $urandom_range(1, 10);
                out_stall = 1'b1;
                repeat (burst - 1) @(negedge clk);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    function automatic logic [ptcs_pkg::SAMPLE_W-1:0] adc_clip(input int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return 12'(v);
    endfunction

    // Leaves valid high after the item is taken; the next call or a drain moves it.
    task automatic send_pedal(input logic [ptcs_pkg::SAMPLE_W-1:0] s0, s1, s2, s3,
                              input logic [ptcs_pkg::GEAR_W-1:0] g);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 99) < 20) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        sample_0 = s0;
        sample_1 = s1;
        sample_2 = s2;
        sample_3 = s3;
        gear     = g;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic load_calibration(input int pmin, input int pmax, input int fwd, input int rev);
        logic [ptcs_pkg::CFG_IDX_W-1:0]  slot [4];
        logic [ptcs_pkg::CFG_DATA_W-1:0] word [4];
        slot = '{ptcs_pkg::REG_PEDAL_MIN, ptcs_pkg::REG_PEDAL_MAX,
                 ptcs_pkg::REG_MAX_FORWARD, ptcs_pkg::REG_MAX_REVERSE};
        word = '{15'(pmin), 15'(pmax), 15'(fwd), 15'(rev)};
        drain_results();
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = slot[i];
            cfg_data  = word[i];
            do @(posedge clk); while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_min   = pmin % 4096;
        cfg_max   = pmax % 4096;
        settings_loaded++;
    endtask

    // Segments hold a gear with the pedal drifting around a level, so the rate
    // limiter and deadband hysteresis get long runs; some segments are pure noise.
    task automatic run_pedal_traffic(input int items);
        int                          left;
        int                          seg_len;
        int                          level;
        int                          lo;
        int                          hi;
        int                          mode;
        logic [ptcs_pkg::GEAR_W-1:0] g;
        lo   = (cfg_min < cfg_max) ? cfg_min : cfg_max;
        hi   = (cfg_min < cfg_max) ? cfg_max : cfg_min;
        left = items;
        while (left > 0) begin
            idling_on = !calm_tail && ($urandom_range(0, 3) != 0);
            seg_len   = $urandom_range(4, 60);
            if (seg_len > left) seg_len = left;
            mode = $urandom_range(0, 19);
            if (mode < 8) begin
                g = ptcs_pkg::GEAR_DRIVE;
            end else if (mode < 14) begin
                g = GEAR_REVERSE;
            end else if (mode < 16) begin
                g = ptcs_pkg::GEAR_NEUTRAL;
            end else begin
                g = GEAR_SPARE;
            end
            level = $urandom_range(lo, hi);
            for (int k = 0; k < seg_len; k++) begin
                if (mode >= 18) begin
                    send_pedal(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                               2'($urandom_range(0, 3)));
                end else begin
                    level = level + int'($urandom_range(0, 64)) - 32;
                    if (level < lo) level = lo;
                    if (level > hi) level = hi;
                    if ($urandom_range(0, 24) == 0) level = lo;
                    send_pedal(adc_clip(level + int'($urandom_range(0, 16)) - 8),
                               adc_clip(level + int'($urandom_range(0, 16)) - 8),
                               adc_clip(level + int'($urandom_range(0, 16)) - 8),
                               adc_clip(level + int'($urandom_range(0, 16)) - 8), g);
                end
            end
            left -= seg_len;
            if ($urandom_range(0, 15) == 0) drain_results();
        end
    endtask

    initial begin : stimulus
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        sample_0        = '0;
        sample_1        = '0;
        sample_2        = '0;
        sample_3        = '0;
        gear            = ptcs_pkg::GEAR_NEUTRAL;
        cfg_valid       = 1'b0;
        cfg_index       = ptcs_pkg::REG_PEDAL_MIN;
        cfg_data        = '0;
        idling_on       = 1'b1;
        calm_tail       = 1'b0;
        items_sent      = 0;
        settings_loaded = 0;
        cfg_min         = 0;
        cfg_max         = int'(ptcs_pkg::PEDAL_MAX_RST);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_calibration(200, 3900, 2000, 1200);
        send_pedal(12'h000, 12'h000, 12'h000, 12'h000, ptcs_pkg::GEAR_DRIVE);
        // full pedal: ramps by 8 per item, through the deadband and out again
        repeat (5) send_pedal(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, ptcs_pkg::GEAR_DRIVE);
        send_pedal(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, ptcs_pkg::GEAR_NEUTRAL);
        repeat (4) send_pedal(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, GEAR_REVERSE);
        repeat (2) send_pedal(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, GEAR_SPARE);
        // 3% throttle: a rising step below 5% is dropped to zero
        send_pedal(12'd311, 12'd311, 12'd311, 12'd311, ptcs_pkg::GEAR_NEUTRAL);
        repeat (2) send_pedal(12'd311, 12'd311, 12'd311, 12'd311, ptcs_pkg::GEAR_DRIVE);
        repeat (2) send_pedal(12'h000, 12'hFFF, 12'h000, 12'hFFF, ptcs_pkg::GEAR_DRIVE);
        send_pedal(12'hFFF, 12'h000, 12'h000, 12'h000, GEAR_REVERSE);
        send_pedal(12'h000, 12'h000, 12'h000, 12'h000, ptcs_pkg::GEAR_NEUTRAL);
        send_pedal(12'hAAA, 12'h555, 12'hAAA, 12'h555, ptcs_pkg::GEAR_DRIVE);

        run_pedal_traffic(170);
        drain_results();
        run_pedal_traffic(170);

        load_calibration(0, 4095, 32767, 32767);
        run_pedal_traffic(300);
        // inverted calibration
        load_calibration(4095, 0, 0, 32767);
        run_pedal_traffic(250);
        // zero calibration span
        load_calibration(1000, 1000, 32767, 0);
        run_pedal_traffic(60);

        repeat (3) begin
            load_calibration(int'($urandom_range(0, 7)) * 4096 + int'($urandom_range(0, 1500)),
                             int'($urandom_range(0, 7)) * 4096 + int'($urandom_range(2000, 4095)),
                             int'($urandom_range(0, 32767)), int'($urandom_range(0, 32767)));
            run_pedal_traffic(260);
        end

        calm_tail = 1'b1;
        idling_on = 1'b0;
        run_pedal_traffic(150);

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("covered %0d pedal items, %0d torque results checked, %0d calibration settings",
                 items_sent, results_checked, settings_loaded);
        $display("with inverted and zero-span calibration, all gear codes and the low-throttle cut");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ptcs_pkg.sv
design/ptcs_div.sv
design/ptcs_ctrl.sv
design/ptcs_dp.sv
design/pedal_torque_command_shaper.sv
sim/ptcs_torque_checker.sv
sim/tb_pedal_torque_command_shaper.sv
